// ===== sv/lsvc_pkg.sv =====
// Package for the looping sample voice: widths, item codes, register indexes
// and the command/status structs between controller and datapath.
// No dependencies.
package lsvc_pkg;

  localparam int NUM_STREAMS = 2;
  localparam int NUM_OUTPUTS = 2;
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 16;
  localparam int GAIN_BITS   = 18;
  localparam int ADDR_BITS   = 16;
  localparam int STEP_BITS   = 23;
  localparam int FRAME_BITS  = 17;
  localparam int POS_BITS    = FRAME_BITS + FRAC_BITS;
  localparam int CFG_BITS    = 17;
  localparam int IN_BITS     = 88;
  localparam int OUT_BITS    = 32;
  localparam int DIV_STEPS   = FRAME_BITS;

  localparam logic [1:0] KIND_LOAD_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_LOAD_GAIN   = 2'd1;
  localparam logic [1:0] KIND_START       = 2'd2;
  localparam logic [1:0] KIND_TICK        = 2'd3;

  localparam logic [1:0] REG_LOOP_ENABLE = 2'd0;
  localparam logic [1:0] REG_LOOP_START  = 2'd1;
  localparam logic [1:0] REG_LOOP_END    = 2'd2;
  localparam logic [1:0] REG_LENGTH      = 2'd3;

  localparam logic [1:0] PH_B    = 2'd0;
  localparam logic [1:0] PH_C    = 2'd1;
  localparam logic [1:0] PH_LAST = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       apply;
    logic       div_start;
    logic       addr_en;
    logic [1:0] tap;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       cap_en;
    logic [2:0] cap_sel;
    logic       coef_en;
    logic       stream;
    logic       mul_en;
    logic       add_en;
    logic [1:0] phase;
    logic       y_en;
    logic       adv_en;
    logic       mix_en;
    logic       mix_stream;
    logic       chan;
    logic       emit;
    logic       emit_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       active;
    logic       need_div;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== sv/looping_sample_voice_cubic_interp_core.sv =====
// Looping sample voice, 4-point Hermite interpolation, 2 streams mixed to 2 outputs.
// Load and start items are captured, then applied. An active render tick runs the serial
// remainder unit first when the first tap lies past loop end. One item in flight; the output
// register frees input. Inactive tick: 2 zero results. Sync active-low reset clears gain table,
// position and voice flags and sets config to defaults (loop end 0x10000); store is not cleared.
module looping_sample_voice_cubic_interp_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // stream_index, out_index, address, sample_value, gain_value, release_req, pitch_step
  input  logic [lsvc_pkg::IN_BITS-1:0]  in_tdata,
  // kind
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // mixed_sample, finished
  output logic [lsvc_pkg::OUT_BITS-1:0] out_tdata,
  // out_channel
  output logic                          out_tuser,
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [lsvc_pkg::CFG_BITS-1:0] cfg_wdata
);
  import lsvc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     div_done;

  lsvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .div_done  (div_done),
    .stat      (stat),
    .cmd       (cmd)
  );

  lsvc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .div_done  (div_done),
    .in_data   (in_tdata),
    .in_kind   (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_chan  (out_tuser),
    .out_last  (out_tlast)
  );

endmodule

// ===== sv/lsvc_mod.sv =====
// Restoring remainder unit, one quotient bit per cycle.
// Depends on lsvc_pkg.
module lsvc_mod (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [lsvc_pkg::FRAME_BITS-1:0] dividend,
  input  logic [lsvc_pkg::FRAME_BITS-1:0] divisor,
  output logic [lsvc_pkg::FRAME_BITS-1:0] rem,
  output logic                            done
);
  import lsvc_pkg::*;

  logic [FRAME_BITS-1:0] num_r, num_nxt;
  logic [FRAME_BITS-1:0] den_r, den_nxt;
  logic [FRAME_BITS:0]   rem_r, rem_nxt;
  logic [4:0]            cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [FRAME_BITS:0]   trial;

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[FRAME_BITS-1:0], num_r[FRAME_BITS-1]};
    if (start) begin
      num_nxt  = dividend;
      den_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[FRAME_BITS-2:0], 1'b0};
      rem_nxt = (trial >= {1'b0, den_r}) ? trial - {1'b0, den_r} : trial;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign rem  = rem_r[FRAME_BITS-1:0];
  assign done = done_r;

endmodule

// ===== sv/lsvc_ctrl.sv =====
// Controller FSM for the sample voice: sequences loads, tap fetch,
// interpolation, position advance, mixing and result hand-off.
// Depends on lsvc_pkg.
module lsvc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               div_done,
  input  lsvc_pkg::dp_stat_t stat,
  output lsvc_pkg::dp_cmd_t  cmd
);
  import lsvc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_ADDR  = 4'd3;
  localparam logic [3:0] S_READ  = 4'd4;
  localparam logic [3:0] S_COEF  = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_ADD   = 4'd7;
  localparam logic [3:0] S_YOUT  = 4'd8;
  localparam logic [3:0] S_ADV   = 4'd9;
  localparam logic [3:0] S_MIX   = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;
  localparam logic [3:0] S_EMITZ = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic       strm_r, strm_nxt;
  logic       chan_r, chan_nxt;
  logic [2:0] cap_idx;

  assign in_tready = (state_r == S_IDLE);
  assign cap_idx   = 3'(cnt_r - 4'd1);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ph_nxt    = ph_r;
    strm_nxt  = strm_r;
    chan_nxt  = chan_r;
    cmd       = '0;
    cmd.tap        = cnt_r[1:0];
    cmd.rd_sel     = cnt_r[2:0];
    cmd.cap_sel    = cap_idx;
    cmd.stream     = strm_r;
    cmd.phase      = ph_r;
    cmd.mix_stream = strm_r;
    cmd.chan       = chan_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        cnt_nxt  = '0;
        chan_nxt = 1'b0;
        strm_nxt = 1'b0;
        ph_nxt   = PH_B;
        if (stat.kind != KIND_TICK) begin
          cmd.apply = 1'b1;
          state_nxt = S_IDLE;
        end else if (!stat.active) begin
          state_nxt = S_EMITZ;
        end else if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_ADDR;
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr_en = 1'b1;
        cnt_nxt     = cnt_r + 4'd1;
        if (cnt_r == 4'd3) begin
          cnt_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // read issued for (tap, stream) = cnt, registered data captured in the next cycle
        cmd.rd_en  = (cnt_r != 4'd8);
        cmd.cap_en = (cnt_r != 4'd0);
        cnt_nxt    = cnt_r + 4'd1;
        if (cnt_r == 4'd8) begin
          cnt_nxt   = '0;
          state_nxt = S_COEF;
        end
      end
      S_COEF: begin
        cmd.coef_en = 1'b1;
        ph_nxt      = PH_B;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_ADD;
      end
      S_ADD: begin
        cmd.add_en = 1'b1;
        if (ph_r == PH_LAST) begin
          state_nxt = S_YOUT;
        end else begin
          ph_nxt    = ph_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_YOUT: begin
        cmd.y_en = 1'b1;
        if (strm_r == 1'b1) begin
          strm_nxt  = 1'b0;
          state_nxt = S_ADV;
        end else begin
          strm_nxt  = 1'b1;
          state_nxt = S_COEF;
        end
      end
      S_ADV: begin
        cmd.adv_en = 1'b1;
        state_nxt  = S_MIX;
      end
      S_MIX: begin
        cmd.mix_en = 1'b1;
        if (strm_r == 1'b1) begin
          strm_nxt  = 1'b0;
          state_nxt = S_EMIT;
        end else begin
          strm_nxt = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (chan_r == 1'b1) begin
            state_nxt = S_IDLE;
          end else begin
            chan_nxt  = 1'b1;
            state_nxt = S_MIX;
          end
        end
      end
      S_EMITZ: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_zero = 1'b1;
          chan_nxt      = 1'b1;
          if (chan_r == 1'b1) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ph_r    <= PH_B;
      strm_r  <= 1'b0;
      chan_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ph_r    <= ph_nxt;
      strm_r  <= strm_nxt;
      chan_r  <= chan_nxt;
    end
  end

  a_div_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> state_r == S_DIV)
    else $error("divider started outside dispatch");
  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result issued while output register occupied");
  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> state_r == S_IDLE)
    else $error("item captured mid-operation");

endmodule

// ===== sv/lsvc_dp.sv =====
// Datapath for the sample voice: item latch, config registers, sample store,
// tap addressing, Hermite interpolation, position advance, mixing, output register.
// Depends on lsvc_pkg and lsvc_mod.
module lsvc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lsvc_pkg::dp_cmd_t                 cmd,
  output lsvc_pkg::dp_stat_t                stat,
  output logic                              div_done,
  input  logic [lsvc_pkg::IN_BITS-1:0]      in_data,
  input  logic [1:0]                        in_kind,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [lsvc_pkg::CFG_BITS-1:0]     cfg_wdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lsvc_pkg::OUT_BITS-1:0]     out_data,
  output logic                              out_chan,
  output logic                              out_last
);
  import lsvc_pkg::*;

  // item latch
  logic [1:0]             it_kind_r;
  logic                   it_sidx_r, it_oidx_r, it_rel_r;
  logic [ADDR_BITS-1:0]   it_addr_r;
  logic [SAMPLE_BITS-1:0] it_sample_r;
  logic [GAIN_BITS-1:0]   it_gain_r;
  logic [STEP_BITS-1:0]   it_step_r;

  // config
  logic                  loop_en_r;
  logic [ADDR_BITS-1:0]  loop_start_r;
  logic [FRAME_BITS-1:0] loop_end_r, length_r;

  // voice state
  logic [POS_BITS-1:0]         pos_r;
  logic                        rel_r, active_r;
  logic signed [GAIN_BITS-1:0] gain_r [NUM_STREAMS*NUM_OUTPUTS];

  // sample store
  logic [SAMPLE_BITS-1:0] mem [NUM_STREAMS*(2**ADDR_BITS)];
  logic [SAMPLE_BITS-1:0] rdata_r;

  // taps
  logic [FRAME_BITS:0]           tap_addr_r [4];
  logic                          tap_zero_r [4];
  logic [FRAME_BITS-1:0]         wr_r;
  logic                          wrapped_r;
  logic signed [SAMPLE_BITS-1:0] x_r [NUM_STREAMS][4];

  // interpolation and mix
  logic signed [31:0] a_r, b_r, c_r, p_r;
  logic signed [48:0] prod_r;
  logic signed [31:0] y_r [NUM_STREAMS];
  logic signed [51:0] acc_r;

  // output register
  logic                   ov_r, oc_r, ol_r, of_r;
  logic [SAMPLE_BITS-1:0] os_r;

  logic [FRAME_BITS-1:0] base, div_rem, loop_len;
  logic                  looping;

  assign base     = pos_r[POS_BITS-1:FRAC_BITS];
  assign looping  = loop_en_r && !rel_r;
  assign loop_len = loop_end_r - {1'b0, loop_start_r};

  assign stat.kind     = it_kind_r;
  assign stat.active   = active_r;
  assign stat.need_div = looping && (loop_end_r > {1'b0, loop_start_r}) && (base >= loop_end_r);
  assign stat.out_free = !ov_r || out_ready;

  lsvc_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (base - loop_end_r),
    .divisor  (loop_len),
    .rem      (div_rem),
    .done     (div_done)
  );

  // item capture and config
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_kind_r   <= in_kind;
      it_sidx_r   <= in_data[0];
      it_oidx_r   <= in_data[1];
      it_addr_r   <= in_data[17:2];
      it_sample_r <= in_data[41:18];
      it_gain_r   <= in_data[59:42];
      it_rel_r    <= in_data[60];
      it_step_r   <= in_data[83:61];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_en_r    <= 1'b0;
      loop_start_r <= '0;
      loop_end_r   <= 17'h10000;
      length_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOOP_ENABLE: loop_en_r    <= cfg_wdata[0];
        REG_LOOP_START:  loop_start_r <= cfg_wdata[ADDR_BITS-1:0];
        REG_LOOP_END:    loop_end_r   <= cfg_wdata;
        REG_LENGTH:      length_r     <= cfg_wdata;
      endcase
    end
  end

  // sample store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.apply && it_kind_r == KIND_LOAD_SAMPLE)
      mem[{it_sidx_r, it_addr_r}] <= it_sample_r;
    if (cmd.rd_en)
      rdata_r <= mem[{cmd.rd_sel[0], tap_addr_r[cmd.rd_sel[2:1]][ADDR_BITS-1:0]}];
  end

  // tap address resolution, one tap per cycle
  logic [FRAME_BITS:0]   idx, rnew1, ta;
  logic [FRAME_BITS-1:0] rnew;
  logic                  hit;
  always_comb begin
    idx   = {1'b0, base} + {16'b0, cmd.tap};
    hit   = looping && (idx >= {1'b0, loop_end_r});
    rnew1 = {1'b0, wr_r} + 18'd1;
    if (cmd.tap != 2'd0 && wrapped_r)
      rnew = (rnew1 == {1'b0, loop_len}) ? '0 : rnew1[FRAME_BITS-1:0];
    else if (cmd.tap == 2'd0)
      rnew = div_rem;
    else
      rnew = '0;
    if (!hit)
      ta = idx;
    else if (loop_end_r <= {1'b0, loop_start_r})
      ta = {2'b0, loop_start_r};
    else
      ta = {2'b0, loop_start_r} + {1'b0, rnew};
  end

  always_ff @(posedge clk) begin
    if (cmd.addr_en) begin
      tap_addr_r[cmd.tap] <= ta;
      tap_zero_r[cmd.tap] <= (ta >= {1'b0, length_r}) || (ta[FRAME_BITS:ADDR_BITS] != 2'b0);
      wr_r                <= rnew;
      wrapped_r           <= hit;
    end
    if (cmd.cap_en)
      x_r[cmd.cap_sel[0]][cmd.cap_sel[2:1]] <=
        tap_zero_r[cmd.cap_sel[2:1]] ? '0 : $signed(rdata_r);
  end

  // Hermite: p = A; p = rnd(p*f)+B; p = rnd(p*f)+C; p = rnd(p*f); y = x1 + rnd(p/2), or x1 at unit step
  logic signed [31:0] x0e, x1e, x2e, x3e, addend, ph1;
  logic signed [48:0] prod_rnd;
  always_comb begin
    x0e = 32'(x_r[cmd.stream][0]);
    x1e = 32'(x_r[cmd.stream][1]);
    x2e = 32'(x_r[cmd.stream][2]);
    x3e = 32'(x_r[cmd.stream][3]);
    prod_rnd = prod_r + 49'sd32768;
    unique case (cmd.phase)
      PH_B:    addend = b_r;
      PH_C:    addend = c_r;
      default: addend = '0;
    endcase
    ph1 = p_r + 32'sd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.coef_en) begin
      a_r <= 32'sd3 * (x1e - x2e) - x0e + x3e;
      b_r <= 32'sd4 * x2e + 32'sd2 * x0e - 32'sd5 * x1e - x3e;
      c_r <= x2e - x0e;
      p_r <= 32'sd3 * (x1e - x2e) - x0e + x3e;
    end else if (cmd.add_en) begin
      p_r <= $signed(prod_rnd[47:16]) + addend;
    end
    if (cmd.mul_en)
      prod_r <= p_r * $signed({1'b0, pos_r[FRAC_BITS-1:0]});
    if (cmd.y_en)
      y_r[cmd.stream] <= (it_step_r == 23'h10000) ? x1e : x1e + (ph1 >>> 1);
  end

  // mix: one stream product per cycle into the channel accumulator
  logic signed [49:0] mix_prod;
  assign mix_prod = y_r[cmd.mix_stream] * gain_r[{cmd.mix_stream, cmd.chan}];
  always_ff @(posedge clk) begin
    if (cmd.mix_en)
      acc_r <= (cmd.mix_stream ? acc_r : 52'sd0) + 52'(mix_prod);
  end

  // voice state: gain table, start, advance
  logic [POS_BITS:0]   sum;
  logic [FRAME_BITS:0] sint;
  assign sum  = {1'b0, pos_r} + {11'b0, it_step_r};
  assign sint = sum[POS_BITS:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      rel_r    <= 1'b0;
      active_r <= 1'b0;
      for (int i = 0; i < NUM_STREAMS*NUM_OUTPUTS; i++) gain_r[i] <= '0;
    end else begin
      if (cmd.apply && it_kind_r == KIND_LOAD_GAIN)
        gain_r[{it_sidx_r, it_oidx_r}] <= $signed(it_gain_r);
      if (cmd.apply && it_kind_r == KIND_START) begin
        pos_r    <= {1'b0, it_addr_r, {FRAC_BITS{1'b0}}};
        rel_r    <= it_rel_r;
        active_r <= 1'b1;
      end
      if (cmd.adv_en) begin
        if (looping) begin
          pos_r <= (sint >= {1'b0, loop_end_r}) ?
                   {1'b0, loop_start_r, {FRAC_BITS{1'b0}}} : sum[POS_BITS-1:0];
        end else if (sint >= {1'b0, length_r}) begin
          pos_r    <= {length_r, {FRAC_BITS{1'b0}}};
          active_r <= 1'b0;
        end else begin
          pos_r <= sum[POS_BITS-1:0];
        end
      end
    end
  end

  // output register with round and saturate
  logic signed [51:0] acc_rnd;
  logic signed [35:0] v;
  logic [SAMPLE_BITS-1:0] sat;
  always_comb begin
    acc_rnd = acc_r + 52'sd32768;
    v       = acc_rnd[51:16];
    if (v > 36'sd8388607)       sat = 24'h7FFFFF;
    else if (v < -36'sd8388608) sat = 24'h800000;
    else                        sat = v[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
    if (cmd.emit) begin
      oc_r <= cmd.chan;
      ol_r <= cmd.chan;
      of_r <= !active_r;
      os_r <= cmd.emit_zero ? '0 : sat;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = {7'b0, of_r, os_r};
  assign out_chan  = oc_r;
  assign out_last  = ol_r;

  a_adv_when_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.adv_en |-> active_r)
    else $error("position advanced on idle voice");
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r[POS_BITS-1:FRAC_BITS] <= 17'h10000)
    else $error("play position beyond sample range");
  a_mul_then_add: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_en |=> cmd.add_en)
    else $error("product not folded back after multiply");

endmodule
